// File: src/bssd_pkg.sv
// ----------------------------------------------------------------------------
// bssd_pkg
// Shared widths, codes and helpers for the seven-segment scan driver.
// ----------------------------------------------------------------------------
package bssd_pkg;

   localparam int NUM_DIGITS  = 4;
   localparam int SCAN_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int VALUE_W     = 16;
   localparam int CODE_W      = 4;
   localparam int BCD_DIGITS  = 4;                    // enough for 9999
   localparam int BCD_W       = BCD_DIGITS * CODE_W;
   localparam int CNT_W       = $clog2(VALUE_W);
   localparam int BYTE_W      = 8;
   localparam int MODE_W      = 2;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 16;

   localparam logic [VALUE_W-1:0] MAX_SHOWN  = VALUE_W'(9999);
   localparam logic [CODE_W-1:0]  BLANK_CODE = 4'hF;
   localparam logic [CODE_W-1:0]  ZERO_CODE  = 4'h0;

   // item kinds carried on tuser
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VALUE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DIGITS = 2'd2;

   // display byte: one-hot select in the high nibble, none beyond position 3
   function automatic logic [BYTE_W-1:0] make_byte(input int unsigned pos,
                                                   input logic [CODE_W-1:0] code);
      logic [BYTE_W-1:0] sel;
      sel = '0;
      if (pos < 4) begin
         sel = BYTE_W'(8'h10 << pos);
      end
      return sel | {4'h0, code};
   endfunction

endpackage

// File: src/bssd_dabble.sv
// ----------------------------------------------------------------------------
// bssd_dabble
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module bssd_dabble (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bssd_pkg::VALUE_W-1:0]   value,
   output logic                           done,
   output logic [bssd_pkg::BCD_W-1:0]     bcd
);
   import bssd_pkg::*;

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [BCD_W-1:0]   adj;

   // add 3 to each digit of 5 or more, then shift in the next binary bit
   always_comb begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
         adj[d*CODE_W +: CODE_W] = (bcd_ff[d*CODE_W +: CODE_W] >= 4'd5)
                                 ? bcd_ff[d*CODE_W +: CODE_W] + 4'd3
                                 : bcd_ff[d*CODE_W +: CODE_W];
      end
   end

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         bin_in   = value;
         bcd_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         bcd_in   = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in   = {bin_ff[VALUE_W-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(VALUE_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

// File: src/bcd_seven_segment_scan_driver.sv
// ----------------------------------------------------------------------------
// bcd_seven_segment_scan_driver
// Four-digit multiplexed display driver with serial binary to BCD loading.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser holds the item kind (tick, load value, load digits);
//   tdata holds the number and the four raw digit codes.
//   rsp channel: one transfer per tick, carrying the display byte of the
//   scanned position (select nibble high, BCD code low) and that position.
// Item handling:
//   Tick: result registered in the cycle after the transfer; one tick per
//   cycle while the receiver keeps up and no value load is converting.
//   Digit load: written straight into the store, with no wait before the next item.
//   Value load: the next item waits until the conversion ends: the converter
//   starts, makes its 16 bit-serial shift-and-add-3 passes, then the store
//   is written. Out-of-range values (0 or above 9999) show a
//   single 0 in the rightmost position.
// Reset: display bytes clear to zero (nothing selected), scan position 0,
//   result register empty.
// Stall: a pending result holds while rsp_tready is low; further ticks wait,
//   loads are still taken.
// ----------------------------------------------------------------------------
module bcd_seven_segment_scan_driver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] binary_value, [19:16] digit_thousands, [23:20] digit_hundreds,
   // [27:24] digit_tens, [31:28] digit_units
   input  logic [bssd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] mode
   input  logic [bssd_pkg::MODE_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] port_byte, [9:8] scan_position, [15:10] zero
   output logic [bssd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import bssd_pkg::*;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_CONVERT
   } state_type;

   state_type          state_ff, state_in;
   logic [BYTE_W-1:0]  store_ff [NUM_DIGITS];
   logic [BYTE_W-1:0]  store_in [NUM_DIGITS];
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic [SCAN_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic               range_bad_ff, range_bad_in;

   logic [VALUE_W-1:0] value;
   logic [CODE_W-1:0]  raw_code [4];
   logic               accept;
   logic               conv_start;
   logic               conv_done;
   logic [BCD_W-1:0]   conv_bcd;
   logic [BCD_DIGITS-1:0] lead_zero;
   logic               out_free;

   assign value       = req_tdata[VALUE_W-1:0];
   assign raw_code[3] = req_tdata[19:16];
   assign raw_code[2] = req_tdata[23:20];
   assign raw_code[1] = req_tdata[27:24];
   assign raw_code[0] = req_tdata[31:28];

   // result slot is free if empty or draining this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && ((req_tuser != MODE_TICK) || out_free);
   assign accept     = req_tvalid && req_tready;
   assign conv_start = accept && (req_tuser == MODE_VALUE);

   bssd_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .value (value),
      .done  (conv_done),
      .bcd   (conv_bcd)
   );

   // positions at and above the leading digit that are all zero get blanked
   always_comb begin
      logic run;
      run = 1'b1;
      for (int d = BCD_DIGITS - 1; d >= 0; d--) begin
         run          = run && (conv_bcd[d*CODE_W +: CODE_W] == ZERO_CODE);
         lead_zero[d] = run;
      end
   end

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      range_bad_in = range_bad_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      for (int p = 0; p < NUM_DIGITS; p++) begin
         store_in[p] = store_ff[p];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_tuser == MODE_TICK) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = store_ff[scan_ff];
                  rsp_pos_in   = scan_ff;
                  scan_in      = (scan_ff == SCAN_W'(NUM_DIGITS - 1))
                               ? '0 : scan_ff + 1'b1;
               end else if (req_tuser == MODE_VALUE) begin
                  range_bad_in = (value == '0) || (value > MAX_SHOWN);
                  state_in     = ST_CONVERT;
               end else if (req_tuser == MODE_DIGITS) begin
                  for (int p = 0; p < NUM_DIGITS; p++) begin
                     if (p < 4) begin
                        store_in[p] = make_byte(p, raw_code[p]);
                     end
                  end
               end else begin
                  // unused kind: dropped
               end
            end
         end
         ST_CONVERT: begin
            if (conv_done) begin
               for (int p = 0; p < NUM_DIGITS; p++) begin
                  if (range_bad_ff) begin
                     store_in[p] = make_byte(p, (p == 0) ? ZERO_CODE : BLANK_CODE);
                  end else if (p < BCD_DIGITS) begin
                     store_in[p] = make_byte(p, lead_zero[p] ? BLANK_CODE
                                                 : conv_bcd[p*CODE_W +: CODE_W]);
                  end else begin
                     store_in[p] = make_byte(p, BLANK_CODE);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         range_bad_ff <= 1'b0;
         for (int p = 0; p < NUM_DIGITS; p++) begin
            store_ff[p] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         range_bad_ff <= range_bad_in;
         for (int p = 0; p < NUM_DIGITS; p++) begin
            store_ff[p] <= store_in[p];
         end
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - BYTE_W - SCAN_W)'(0), rsp_pos_ff, rsp_byte_ff};

endmodule

// File: test/bcd_seven_segment_scan_driver_test.sv
// ----------------------------------------------------------------------------
// bcd_seven_segment_scan_driver_test
// Self-checking bench for the multiplexed seven-segment scan driver. A queue
// of items (ticks, binary value loads, raw digit loads, unused kind) is
// filled up front and fed by a clocked driver with random gaps; a clocked
// monitor keeps a model of the display store and scan position, predicts the
// byte of every tick and checks each response transfer against it.
// ----------------------------------------------------------------------------
module bcd_seven_segment_scan_driver_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bssd_pkg::*;

   // the kind code with no meaning; the block takes it and does nothing
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1700;
   localparam int IDLE_PCT     = 22;
   localparam int DRAIN_CYCLES = 40;    // room for a value load to finish
   localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
      logic [CODE_W-1:0]  thousands;
      logic [CODE_W-1:0]  hundreds;
      logic [CODE_W-1:0]  tens;
      logic [CODE_W-1:0]  units;
      bit                 hold;    // wait for all owed bytes before sending
   } display_item_type;

   typedef struct {
      logic [BYTE_W-1:0] port_byte;
      logic [SCAN_W-1:0] scan_position;
   } scan_byte_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   display_item_type send_q[$];
   scan_byte_type    port_byte_due[$];

   int items_sent = 0;   // accepted request transfers
   int bytes_owed = 0;   // registered copy of the due queue depth
   int quiet      = 0;
   int faults     = 0;

   // display model
   logic [BYTE_W-1:0] shown [NUM_DIGITS];
   logic [SCAN_W-1:0] scan_at;

   // no idling on either side while this holds
   wire calm = (items_sent >= 900) && (items_sent < 1200);

   always #2 clock = ~clock;

   bcd_seven_segment_scan_driver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ---------------------------------------------------------------------
   // model helpers
   // ---------------------------------------------------------------------

   // select bit for positions 0..3 only, code in the low nibble
   function automatic logic [BYTE_W-1:0] digit_byte(input int unsigned pos,
                                                    input logic [CODE_W-1:0] code);
      logic [BYTE_W-1:0] sel;
      sel = (pos < 4) ? (BYTE_W'(1) << (pos + 4)) : '0;
      return {sel[7:4], code};
   endfunction

   // binary to decimal with leading blanks; 0 and > 9999 show a lone 0
   task automatic load_number(input logic [VALUE_W-1:0] v);
      int unsigned n;
      int unsigned p;
      n = v;
      for (p = 0; p < NUM_DIGITS; p++) begin
         shown[p] = digit_byte(p, BLANK_CODE);
      end
      if (n > 0 && n <= MAX_SHOWN) begin
         p = 0;
         while (n > 0) begin
            if (p < NUM_DIGITS) begin
               shown[p] = digit_byte(p, CODE_W'(n % 10));
            end
            n = n / 10;
            p++;
         end
      end else begin
         shown[0] = digit_byte(0, ZERO_CODE);
      end
   endtask

   task automatic note_fault(input string what);
      if (faults < MAX_REPORTS) begin
         $display("mismatch: %s", what);
      end
      faults++;
   endtask

   // ---------------------------------------------------------------------
   // item builders
   // ---------------------------------------------------------------------

   function automatic display_item_type blank_item(input logic [MODE_W-1:0] m);
      display_item_type it;
      it.mode      = m;
      it.value     = '0;
      it.thousands = '0;
      it.hundreds  = '0;
      it.tens      = '0;
      it.units     = '0;
      it.hold      = 1'b0;
      return it;
   endfunction

   function automatic display_item_type value_item(input logic [VALUE_W-1:0] v);
      display_item_type it;
      it       = blank_item(MODE_VALUE);
      it.value = v;
      return it;
   endfunction

   function automatic display_item_type digits_item(input logic [CODE_W-1:0] th,
                                                    input logic [CODE_W-1:0] hu,
                                                    input logic [CODE_W-1:0] te,
                                                    input logic [CODE_W-1:0] un);
      display_item_type it;
      it           = blank_item(MODE_DIGITS);
      it.thousands = th;
      it.hundreds  = hu;
      it.tens      = te;
      it.units     = un;
      return it;
   endfunction

   // random item; unused fields carry random junk so every bit toggles
   function automatic display_item_type random_item();
      display_item_type it;
      int unsigned      pick;
      it.value     = VALUE_W'($urandom);
      it.thousands = CODE_W'($urandom);
      it.hundreds  = CODE_W'($urandom);
      it.tens      = CODE_W'($urandom);
      it.units     = CODE_W'($urandom);
      it.hold      = 1'b0;
      pick = $urandom_range(99);
      if (pick < 50) begin
         it.mode = MODE_TICK;
      end else if (pick < 75) begin
         it.mode = MODE_VALUE;
         // spread over digit counts and the out-of-range band
         case ($urandom_range(7))
            0: it.value = VALUE_W'($urandom_range(9, 1));
            1: it.value = VALUE_W'($urandom_range(99, 10));
            2: it.value = VALUE_W'($urandom_range(999, 100));
            3, 4: it.value = VALUE_W'($urandom_range(9999, 1000));
            5: it.value = '0;
            6: it.value = VALUE_W'($urandom_range(65535, 10000));
            default: ;
         endcase
      end else if (pick < 95) begin
         it.mode = MODE_DIGITS;
      end else begin
         it.mode = MODE_UNUSED;
      end
      return it;
   endfunction

   // ---------------------------------------------------------------------
   // driver: one transfer at a time from send_q, random gaps between them
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : feed
      display_item_type nx;
      bit               gap;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            items_sent <= items_sent + 1;
         end
         gap = !calm && ($urandom_range(99) < IDLE_PCT);
         // a held item waits for an idle cycle with nothing owed, so the
         // count it reads already covers every accepted tick
         if (send_q.size() != 0 && !gap &&
             (!send_q[0].hold || (!req_tvalid && bytes_owed == 0))) begin
            nx = send_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nx.mode;
            req_tdata  <= {nx.units, nx.tens, nx.hundreds, nx.thousands, nx.value};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // monitor: check the response transfer first, then fold in the request
   // transfer of the same edge, so the outcome never depends on ordering
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch
      scan_byte_type want;
      scan_byte_type got;
      int            i;
      if (reset) begin
         for (i = 0; i < NUM_DIGITS; i++) begin
            shown[i] = '0;
         end
         scan_at = '0;
         port_byte_due.delete();
         bytes_owed <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.port_byte     = rsp_tdata[7:0];
            got.scan_position = rsp_tdata[9:8];
            if (port_byte_due.size() == 0) begin
               note_fault($sformatf("response %03h with nothing expected", rsp_tdata));
            end else begin
               want = port_byte_due.pop_front();
               if (got.port_byte !== want.port_byte) begin
                  note_fault($sformatf("port_byte expected %02h got %02h",
                                       want.port_byte, got.port_byte));
               end
               if (got.scan_position !== want.scan_position) begin
                  note_fault($sformatf("scan_position expected %0d got %0d",
                                       want.scan_position, got.scan_position));
               end
            end
         end

         if (req_tvalid && req_tready) begin
            case (req_tuser)
               MODE_TICK: begin
                  want.port_byte     = shown[scan_at];
                  want.scan_position = scan_at;
                  port_byte_due.push_back(want);
                  scan_at = (scan_at == SCAN_W'(NUM_DIGITS - 1)) ? '0 : scan_at + 1'b1;
               end
               MODE_VALUE: begin
                  load_number(req_tdata[15:0]);
               end
               MODE_DIGITS: begin
                  // units sit in the top nibble of tdata, thousands lowest
                  shown[0] = digit_byte(0, req_tdata[31:28]);
                  shown[1] = digit_byte(1, req_tdata[27:24]);
                  shown[2] = digit_byte(2, req_tdata[23:20]);
                  shown[3] = digit_byte(3, req_tdata[19:16]);
               end
               default: ;   // unused kind: no result, no change
            endcase
         end
         bytes_owed <= port_byte_due.size();
      end
   end

   // watchdog: too long without a transfer on either channel
   always @(posedge clock) begin
      if (reset) begin
         quiet <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      display_item_type it;
      int               counted;

      // directed: reset bytes, out-of-range values, widest and narrowest
      // numbers, raw code extremes, the unused kind
      send_q.push_back(blank_item(MODE_TICK));        // store still zero
      send_q.push_back(blank_item(MODE_TICK));
      send_q.push_back(value_item(16'd0));             // lone 0
      send_q.push_back(blank_item(MODE_TICK));
      send_q.push_back(blank_item(MODE_TICK));
      send_q.push_back(value_item(16'hFFFF));          // above range
      send_q.push_back(blank_item(MODE_TICK));
      send_q.push_back(value_item(16'd10000));         // just above range
      send_q.push_back(blank_item(MODE_TICK));
      send_q.push_back(value_item(16'd9999));          // all four digits
      send_q.push_back(blank_item(MODE_TICK));
      send_q.push_back(blank_item(MODE_TICK));
      send_q.push_back(blank_item(MODE_TICK));
      send_q.push_back(blank_item(MODE_TICK));
      send_q.push_back(value_item(16'd1));             // three leading blanks
      send_q.push_back(blank_item(MODE_TICK));
      send_q.push_back(value_item(16'd1000));          // inner zeros kept
      send_q.push_back(blank_item(MODE_TICK));
      send_q.push_back(digits_item(4'hF, 4'hF, 4'hF, 4'hF));
      send_q.push_back(blank_item(MODE_TICK));
      it = digits_item(4'hF, 4'hF, 4'hF, 4'hF);
      it.mode  = MODE_UNUSED;                          // must change nothing
      it.value = 16'hFFFF;
      send_q.push_back(it);
      send_q.push_back(digits_item(4'h0, 4'h0, 4'h0, 4'h0));
      send_q.push_back(blank_item(MODE_TICK));
      send_q.push_back(blank_item(MODE_TICK));
      it = blank_item(MODE_TICK);
      it.hold = 1'b1;                                  // drain before random part
      send_q.push_back(it);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         it = random_item();
         if (it.mode != MODE_UNUSED) begin
            counted++;
            if (counted == 700 || counted == 1400) begin
               it.hold = 1'b1;
            end
         end
         send_q.push_back(it);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (send_q.size() != 0 || req_tvalid) @(negedge clock);
      while (port_byte_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (port_byte_due.size() != 0) begin
         note_fault($sformatf("%0d expected bytes never came", port_byte_due.size()));
      end

      if (faults == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
